FILE: hdl/ita_pkg.sv
// shared types, constants and state codes of the integer to ascii formatter
package ita_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FIELD_WIDTH = 32;
  localparam int USED_WIDTH  = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
  localparam logic [FIELD_WIDTH-1:0] VALUE_MASK =
    {FIELD_WIDTH{1'b1}} >> (FIELD_WIDTH - USED_WIDTH);

  localparam int DIGIT_DEPTH = 10;
  localparam int IDX_W       = $clog2(DIGIT_DEPTH);
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 4;

  // reciprocal of ten scaled by 2**35, exact for every 32-bit dividend
  localparam logic [FIELD_WIDTH-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                     RECIP_SHIFT = 35;
  localparam int                     QUOT_W      = 2 * FIELD_WIDTH - RECIP_SHIFT;

  localparam logic [DIGIT_W-1:0] DEC_BASE   = 4'd10;
  localparam int                 HEX_SHIFT  = 4;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;

  typedef enum logic {
    CMD_DEC = 1'b0,
    CMD_HEX = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] value;
    logic                   command;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic convert_step;
    logic emit_step;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic emit_last;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_BASE) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - DEC_BASE);
    end
    return c;
  endfunction

endpackage

FILE: hdl/ita_ctrl.sv
// controller state machine of the integer to ascii formatter
module ita_ctrl import ita_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (status_i.conv_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_CONVERT: cmd_o.convert_step = 1'b1;
      ST_EMIT:    cmd_o.emit_step    = 1'b1;
      default:    busy               = 1'b0;
    endcase
  end

endmodule

FILE: hdl/ita_datapath.sv
// digit extraction, digit store and result register of the formatter
module ita_datapath import ita_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_item_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic       result_strobe_o,
  output out_item_t  result_o
);

  logic [FIELD_WIDTH-1:0] q_q, q_d;
  logic                   hex_q, hex_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [DIGIT_W-1:0]     store_q [DIGIT_DEPTH];
  logic                   strobe_q, strobe_d;
  out_item_t              res_q, res_d;

  logic [2*FIELD_WIDTH-1:0] prod;
  logic [FIELD_WIDTH-1:0]   quot;
  logic [FIELD_WIDTH-1:0]   quot_x10;
  logic [DIGIT_W-1:0]       dec_rem;
  logic [DIGIT_W-1:0]       digit;
  logic [FIELD_WIDTH-1:0]   q_next;
  logic [DIGIT_W-1:0]       emit_digit;

  // divide by ten through the reciprocal, remainder from the low bits
  assign prod     = {{FIELD_WIDTH{1'b0}}, q_q} * {{FIELD_WIDTH{1'b0}}, RECIP_TEN};
  assign quot     = FIELD_WIDTH'(prod[2*FIELD_WIDTH-1:RECIP_SHIFT]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign dec_rem  = q_q[DIGIT_W-1:0] - quot_x10[DIGIT_W-1:0];

  assign digit  = (hex_q == CMD_HEX) ? q_q[DIGIT_W-1:0] : dec_rem;
  assign q_next = (hex_q == CMD_HEX) ? (q_q >> HEX_SHIFT) : quot;

  assign status_o = '{
    conv_last: (q_next == '0) || (cnt_q == IDX_W'(DIGIT_DEPTH - 1)),
    emit_last: (idx_q == '0)
  };

  assign emit_digit = store_q[idx_q];

  always_comb begin
    q_d      = q_q;
    hex_d    = hex_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    if (cmd_i.load) begin
      q_d   = in_item_i.value & VALUE_MASK;
      hex_d = in_item_i.command;
      cnt_d = '0;
    end else if (cmd_i.convert_step) begin
      q_d   = q_next;
      cnt_d = cnt_q + IDX_W'(1);
      idx_d = cnt_q;
    end else if (cmd_i.emit_step) begin
      idx_d            = idx_q - IDX_W'(1);
      strobe_d         = 1'b1;
      res_d.digit_char = digit_ascii(emit_digit);
      res_d.last       = (idx_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    hex_q <= hex_d;
    res_q <= res_d;
    if (cmd_i.convert_step) begin
      store_q[cnt_q] <= digit;
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

endmodule

FILE: hdl/integer_to_ascii_formatter.sv
// top level of the unsigned integer to decimal or hex ascii formatter
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------
//   command  | in        | start and not busy   | in_item_i  (value, command)
//   result   | out       | result_strobe_o      | result_o   (digit_char, last)
//
// a value keeps busy high from the accepting edge until its last digit is read:
// one digit per cycle out of the divide-by-ten or shift unit, then one
// digit per cycle read from the digit store, most significant first;
// each result appears in the cycle after its read, through the output register
// reset clears the state machine, counters and strobe; start is taken again
// once busy falls after the final digit is read out, results cannot be stalled
module integer_to_ascii_formatter import ita_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item_i,
  output logic      result_strobe_o,
  output out_item_t result_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  ita_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (dp_status),
    .cmd_o    (dp_cmd),
    .busy     (busy)
  );

  ita_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_item_i       (in_item_i),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

`ifndef ASSERT_OFF
  // accepted transfer starts the conversion
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transfer");

  // digits of one number come on consecutive cycles
  a_digits_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !result_o.last) |=> result_strobe_o)
    else $error("gap inside a digit string");

  // no result directly after the final digit
  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.last) |=> !result_strobe_o)
    else $error("result right after final digit");

  // digit codes are '0'-'9' or 'A'-'F'
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |->
      ((result_o.digit_char >= ASCII_ZERO && result_o.digit_char <= 7'h39) ||
       (result_o.digit_char >= ASCII_A && result_o.digit_char <= 7'h46)))
    else $error("digit code out of range");
`endif

endmodule

FILE: tb/sv/integer_to_ascii_formatter_tb.sv
// self-checking testbench of the integer to ascii formatter: directed and random values
module integer_to_ascii_formatter_tb;
  import ita_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DEC_RADIX   = 10;
  localparam int HEX_RADIX   = 16;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h41;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      result_strobe;
  out_item_t result;

  out_item_t expected_digits[$];
  out_item_t oldest_digit;
  bit        start_req;
  int        error_count;
  int        values_sent;
  int        digits_checked;
  int        cycle_count;
  int        idle_pct;

  integer_to_ascii_formatter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_item_i      (in_item),
    .result_strobe_o(result_strobe),
    .result_o       (result)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // digits of the masked value, most significant first, last flag on the final one
  task automatic predict_digits(input logic [FIELD_WIDTH-1:0] value, input cmd_e cmd);
    logic [FIELD_WIDTH-1:0] rest;
    logic [DIGIT_W-1:0]     digits[$];
    out_item_t              item;
    int                     radix;
    radix = (cmd == CMD_HEX) ? HEX_RADIX : DEC_RADIX;
    rest  = value & VALUE_MASK;
    do begin
      digits.push_front(DIGIT_W'(rest % radix));
      rest = rest / radix;
    end while (rest != 0);
    foreach (digits[k]) begin
      if (digits[k] < DEC_RADIX) begin
        item.digit_char = CHAR_ZERO + CHAR_W'(digits[k]);
      end else begin
        item.digit_char = CHAR_LETTER + CHAR_W'(digits[k] - DEC_RADIX);
      end
      item.last = (k == digits.size() - 1);
      expected_digits.push_back(item);
    end
  endtask

  task automatic lower_start();
    if (start_req) begin
      start     <= 1'b0;
      start_req = 1'b0;
    end
  endtask

  // one command transfer; start stays high for a back-to-back follower
  task automatic send_value(input logic [FIELD_WIDTH-1:0] value, input cmd_e cmd);
    start         <= 1'b1;
    start_req     = 1'b1;
    in_item.value   <= value;
    in_item.command <= cmd;
    do @(posedge clk_i); while (busy);
    predict_digits(value, cmd);
    values_sent++;
  endtask

  task automatic sender_gap();
    if (idle_pct != 0 && $urandom_range(9) == 0) begin
      lower_start();
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
    while ($urandom_range(99) < idle_pct) begin
      lower_start();
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    lower_start();
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [FIELD_WIDTH-1:0] random_value();
    logic [FIELD_WIDTH-1:0] p;
    case ($urandom_range(4))
      0, 1: random_value = $urandom;
      2: random_value = $urandom >> $urandom_range(FIELD_WIDTH - 1);
      3: random_value = $urandom_range(0, 255);
      default: begin
        p = 1;
        if ($urandom_range(1)) begin
          repeat ($urandom_range(1, 9)) p = p * DEC_RADIX;
        end else begin
          repeat ($urandom_range(1, 7)) p = p * HEX_RADIX;
        end
        random_value = p - $urandom_range(1);
      end
    endcase
  endfunction

  task automatic test_directed();
    logic [FIELD_WIDTH-1:0] values[] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd15, 32'd16, 32'd999999999, 32'd1000000000,
      32'hFFFF_FFFF, 32'h8000_0000, 32'hABCD_EF01, 32'h1234_5678
    };
    idle_pct = 0;
    foreach (values[k]) begin
      send_value(values[k], CMD_DEC);
      send_value(values[k], CMD_HEX);
    end
    wait_drained();
  endtask

  task automatic test_random(input int count, input int pct);
    idle_pct = pct;
    repeat (count) begin
      send_value(random_value(), cmd_e'($urandom_range(1)));
      sender_gap();
    end
    wait_drained();
  endtask

  // sender holds off until every digit of the previous value has come out
  task automatic test_drain_pause();
    repeat (6) begin
      send_value(random_value(), cmd_e'($urandom_range(1)));
      wait_drained();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe) begin
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit %h last %b", result.digit_char, result.last));
      end else begin
        oldest_digit = expected_digits.pop_front();
        digits_checked++;
        if (result.digit_char !== oldest_digit.digit_char) begin
          report_mismatch($sformatf("digit_char %h, want %h",
                                    result.digit_char, oldest_digit.digit_char));
        end
        if (result.last !== oldest_digit.last) begin
          report_mismatch($sformatf("last %b, want %b", result.last, oldest_digit.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits outstanding",
               cycle_count, expected_digits.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    start_req = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(40, 0);
    test_random(40, 48);
    test_random(40, 37);
    test_drain_pause();

    lower_start();
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);

    $display("covered %0d decimal and hex values, %0d digits checked",
             values_sent, digits_checked);
    $display("sender idling at 0, 48 and 37 percent, with drained pauses");
    if (error_count == 0 && expected_digits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
